// ===== rtl/additive_lagged_fibonacci_rng_core_assert.svh =====
// Assertion macros for the additive lagged-Fibonacci generator core.
// No dependencies; included by the core module, which checks its own logic.
`ifndef ADDITIVE_LAGGED_FIBONACCI_RNG_CORE_ASSERT_SVH
`define ADDITIVE_LAGGED_FIBONACCI_RNG_CORE_ASSERT_SVH

// Check a property on every rising edge outside of reset.
`define ALF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ALF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/alf_pkg.sv =====
// Package for the additive lagged-Fibonacci generator core.
// Holds widths, table constants and pointer helpers; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alf_pkg;

	localparam int TABLE_DEPTH  = 33;
	localparam int START_OFFSET = 12;
	localparam int WARMUP_MULT  = 10;
	localparam int WARM_DRAWS   = WARMUP_MULT * TABLE_DEPTH;
	localparam int WARM_CNT_W   = $clog2(WARM_DRAWS + 2);

	typedef logic [31:0] word_t;
	typedef logic [30:0] rand_t;
	typedef logic [5:0]  ptr_t;

	localparam ptr_t  TOP_INDEX   = 6'(TABLE_DEPTH - 1);
	localparam ptr_t  LOWER_START = 6'(START_OFFSET);
	localparam word_t LCG_MUL     = 32'd1103515245;
	localparam word_t LCG_ADD     = 32'd12345;

	// Command codes carried on cmd
	localparam logic  CMD_DRAW    = 1'b0;
	localparam logic  CMD_RESEED  = 1'b1;

	// Table contents after reset
	localparam word_t RESET_TABLE [TABLE_DEPTH] = '{
		32'hd53f1852, 32'hdfc78b83, 32'h4f256096, 32'h0e643df7,
		32'h82c359bf, 32'hc7794dfa, 32'hd5e9ffaa, 32'h2c8cb64a,
		32'h2f07b334, 32'had5a7eb5, 32'h96dc0cde, 32'h6fc24589,
		32'ha5853646, 32'he71576e2, 32'h0dae30df, 32'hb09ce711,
		32'h5e56ef87, 32'h4b4b0082, 32'h6f4f340e, 32'hc5bb17e8,
		32'hd788d765, 32'h67498087, 32'h9d7aba26, 32'h261351d4,
		32'h411ee7ea, 32'h0393a263, 32'h2c5a5835, 32'hc115fcd8,
		32'h25e9132c, 32'hd0c6e906, 32'hc2bc5b2d, 32'h6c065c98,
		32'h6e37bd55
	};

	// Look up the reset word; an index past the top reads the top word
	function automatic word_t reset_word(input ptr_t idx);
		word_t w;
		if (idx > TOP_INDEX) begin
			w = RESET_TABLE[TOP_INDEX];
		end else begin
			w = RESET_TABLE[idx];
		end
		return w;
	endfunction

	// Step a pointer down, wrapping from zero to the top entry
	function automatic ptr_t step_down(input ptr_t p);
		ptr_t n;
		if (p == '0) begin
			n = TOP_INDEX;
		end else begin
			n = p - 6'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/additive_lagged_fibonacci_rng_core.sv =====
// Additive lagged-Fibonacci generator core: 33-word lag table in a RAM.
// Depends on alf_pkg and additive_lagged_fibonacci_rng_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken when start is high and busy is low. A draw
// (cmd = 0) goes in order: the accept cycle reads both lag words from the
// table RAM's registered read ports, the next cycle adds them and writes the
// sum back. The result appears on random_value with done high for exactly
// one cycle, the cycle after that write, and must be captured then: there
// is no way to hold it. A new transaction may be accepted in that same
// cycle, while the result is shown. A reseed (cmd = 1) gives no
// result and keeps busy high through the LCG fill, one table word per cycle,
// then 330 discarded warm-up draws through the same RAM read and write-back
// path. After reset the table reads as its fixed constants at once; no
// clearing pass is needed.
module additive_lagged_fibonacci_rng_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire               cmd,
	input  alf_pkg::word_t    seed_value,
	output alf_pkg::rand_t    random_value,
	output logic              done
);

	import alf_pkg::*;

	`include "additive_lagged_fibonacci_rng_core_assert.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DRAW = 3'd1;
	localparam logic [2:0] ST_FILL = 3'd2;
	localparam logic [2:0] ST_WRD  = 3'd3;
	localparam logic [2:0] ST_WWB  = 3'd4;

	logic [2:0]            state_q;
	ptr_t                  k_q;
	ptr_t                  j_q;
	ptr_t                  fill_q;
	word_t                 lcg_q;
	logic [WARM_CNT_W-1:0] warm_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic                  done_q;
	rand_t                 rand_q;

	word_t                 mem [TABLE_DEPTH];
	word_t                 rd_k_s1;
	word_t                 rd_j_s1;
	logic                  vk_s1;
	logic                  vj_s1;

	logic                  accept;
	logic                  we;
	ptr_t                  wa;
	word_t                 wd;
	word_t                 op_k;
	word_t                 op_j;
	word_t                 sum;
	logic                  wb;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign random_value = rand_q;

	// Pick live words; entries never written read as their reset constant
	assign op_k = vk_s1 ? rd_k_s1 : reset_word(k_q);
	assign op_j = vj_s1 ? rd_j_s1 : reset_word(j_q);
	assign sum  = op_k + op_j;
	assign wb   = (state_q == ST_DRAW) || (state_q == ST_WWB);

	// Select the write port source: LCG fill or sum write-back
	always_comb begin
		we = 1'b0;
		wa = k_q;
		wd = sum;
		if (state_q == ST_FILL) begin
			we = 1'b1;
			wa = fill_q;
			wd = lcg_q;
		end else if (wb) begin
			we = 1'b1;
		end
	end

	// Table RAM: one write port, two registered read ports at the pointers
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_k_s1 <= mem[k_q];
		rd_j_s1 <= mem[j_q];
		vk_s1   <= vld_q[k_q];
		vj_s1   <= vld_q[j_q];
	end

	// Hold the result word for the strobe cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW) begin
			rand_q <= sum[31:1];
		end
	end

	// Advance the LCG one word per fill cycle
	always_ff @(posedge clk) begin
		if (accept && cmd) begin
			lcg_q <= seed_value;
		end else if (state_q == ST_FILL) begin
			lcg_q <= lcg_q * LCG_MUL + LCG_ADD;
		end
	end

	// Sequence draws, fill and warm-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= TOP_INDEX;
			j_q     <= LOWER_START;
			fill_q  <= '0;
			warm_q  <= '0;
			vld_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DRAW);
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (wb) begin
				k_q <= step_down(k_q);
				j_q <= step_down(j_q);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd) begin
							fill_q  <= '0;
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_DRAW;
						end
					end
				end
				ST_DRAW: begin
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == TOP_INDEX) begin
						k_q    <= TOP_INDEX;
						j_q    <= LOWER_START;
						warm_q <= WARM_CNT_W'(WARM_DRAWS);
						if (WARM_DRAWS == 0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WRD;
						end
					end
				end
				ST_WRD: begin
					state_q <= ST_WWB;
				end
				ST_WWB: begin
					warm_q <= warm_q - WARM_CNT_W'(1);
					if (warm_q == WARM_CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WRD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Strobe only follows a user draw write-back
	`ALF_ASSERT(a_done_after_draw, clk, arst_n, done |-> ($past(state_q) == ST_DRAW), "done without draw")
	// Pointers stay in range and never coincide
	`ALF_ASSERT(a_ptr_ok, clk, arst_n, (k_q <= TOP_INDEX) && (j_q <= TOP_INDEX) && (k_q != j_q), "bad pointers")
	// An accepted reseed starts the table fill
	`ALF_ASSERT(a_seed_fill, clk, arst_n, (accept && cmd) |=> (state_q == ST_FILL), "reseed not filling")
	// Each draw write-back moves the upper pointer
	`ALF_ASSERT(a_k_moves, clk, arst_n, (state_q == ST_DRAW) |=> (k_q != $past(k_q)), "pointer stuck")

endmodule

`default_nettype wire

// ===== dv/alf_rng_checker.sv =====
// Checker for the additive lagged-Fibonacci generator core: watches the command
// and result ports, predicts every draw and compares it. Depends on alf_pkg.
`timescale 1ns / 1ps

module alf_rng_checker (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire             busy,
	input  wire             cmd,
	input  alf_pkg::word_t  seed_value,
	input  alf_pkg::rand_t  random_value,
	input  wire             done,
	output int              err_count,
	output int              draws_pending
);
	import alf_pkg::*;

	localparam int MAX_REPORTS = 10;

	// Predicted generator state
	word_t lag_words [TABLE_DEPTH];
	ptr_t  upper_idx;
	ptr_t  lower_idx;

	// Draw values predicted but not yet seen on the result port
	rand_t pending_rand [$];

	// Restore the power-up table and pointers
	function automatic void load_reset_table();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			lag_words[i] = RESET_TABLE[i];
		end
		upper_idx = TOP_INDEX;
		lower_idx = LOWER_START;
	endfunction

	// Add the two lagged words, write the sum back, step both pointers down
	function automatic rand_t advance_lag();
		ptr_t  k;
		ptr_t  j;
		word_t sum;
		k = (upper_idx > TOP_INDEX) ? TOP_INDEX : upper_idx;
		j = (lower_idx > TOP_INDEX) ? TOP_INDEX : lower_idx;
		sum = lag_words[k] + lag_words[j];
		lag_words[k] = sum;
		upper_idx = (k == '0) ? TOP_INDEX : ptr_t'(k - 6'd1);
		lower_idx = (j == '0) ? TOP_INDEX : ptr_t'(j - 6'd1);
		return sum[31:1];
	endfunction

	// Fill the table from the seed by the LCG, then run the silent warm-up
	function automatic void reseed_lag(input word_t seed);
		rand_t rand_discard;
		lag_words[0] = seed;
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			lag_words[i] = lag_words[i - 1] * LCG_MUL + LCG_ADD;
		end
		upper_idx = TOP_INDEX;
		lower_idx = LOWER_START;
		for (int i = 0; i < WARM_DRAWS; i++) begin
			rand_discard = advance_lag();
		end
	endfunction

	// Compare results, then fold in the transaction taken at this edge
	always @(posedge clk or negedge arst_n) begin
		rand_t exp_val;
		if (!arst_n) begin
			load_reset_table();
			pending_rand.delete();
			err_count = 0;
			draws_pending = 0;
		end else begin
			if (done) begin
				if (pending_rand.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$display("%0t: result with no draw pending: random_value=%08h",
							$realtime, random_value);
					end
				end else begin
					exp_val = pending_rand.pop_front();
					if (random_value !== exp_val) begin
						err_count++;
						if (err_count <= MAX_REPORTS) begin
							$display("%0t: random_value mismatch: expected %08h, got %08h",
								$realtime, exp_val, random_value);
						end
					end
				end
			end
			if (start && !busy) begin
				if (cmd == CMD_RESEED) begin
					reseed_lag(seed_value);
				end else begin
					pending_rand.push_back(advance_lag());
				end
			end
			draws_pending = pending_rand.size();
		end
	end

endmodule

// ===== dv/tb_additive_lagged_fibonacci_rng_core.sv =====
// Testbench top for the additive lagged-Fibonacci generator core: drives draw
// and reseed transactions in bursts. Depends on alf_pkg, the core and alf_rng_checker.
`timescale 1ns / 1ps

module tb_additive_lagged_fibonacci_rng_core;
	import alf_pkg::*;

	localparam int NUM_ITEMS   = 450;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 8;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  cmd = CMD_DRAW;
	word_t seed_value = '0;
	logic  busy;
	rand_t random_value;
	logic  done;
	int    err_count;
	int    draws_pending;
	int    cycle_cnt = 0;
	int    items_sent = 0;

	always #4 clk = ~clk;

	additive_lagged_fibonacci_rng_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.seed_value   (seed_value),
		.random_value (random_value),
		.done         (done)
	);

	alf_rng_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.seed_value    (seed_value),
		.random_value  (random_value),
		.done          (done),
		.err_count     (err_count),
		.draws_pending (draws_pending)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_additive_lagged_fibonacci_rng_core NOT OK");
			$finish;
		end
	end

	// Present one transaction at a falling edge and hold it until taken;
	// start stays high so a following call can chain without a gap
	task automatic issue(input logic op, input word_t seed);
		cmd = op;
		seed_value = seed;
		start = 1'b1;
		do begin
			@(posedge clk);
		end while (!(start && !busy));
		@(negedge clk);
		items_sent++;
	endtask

	// Drop start for a number of cycles, with noise on the idle fields
	task automatic idle_for(input int cycles);
		start = 1'b0;
		repeat (cycles) begin
			cmd = 1'($urandom);
			seed_value = $urandom;
			@(negedge clk);
		end
	endtask

	// Hold off until every predicted draw has come back
	task automatic drain_draws();
		start = 1'b0;
		while (draws_pending != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic word_t pick_seed();
		word_t s;
		case ($urandom_range(0, 7))
			0: s = '0;
			1: s = '1;
			2: s = word_t'(1) << $urandom_range(0, 31);
			3: s = ~(word_t'(1) << $urandom_range(0, 31));
			default: s = $urandom;
		endcase
		return s;
	endfunction

	initial begin
		int burst_len;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: draws from the power-up table, then reseeds at the extremes,
		// all back to back
		repeat (4) issue(CMD_DRAW, $urandom);
		issue(CMD_RESEED, 32'h0000_0000);
		repeat (3) issue(CMD_DRAW, 32'hffff_ffff);
		issue(CMD_RESEED, 32'hffff_ffff);
		repeat (3) issue(CMD_DRAW, 32'h0000_0000);
		issue(CMD_RESEED, 32'h8000_0000);
		repeat (2) issue(CMD_DRAW, $urandom);
		issue(CMD_RESEED, 32'h0000_0001);
		repeat (2) issue(CMD_DRAW, $urandom);
		issue(CMD_RESEED, 32'h5555_aaaa);
		issue(CMD_DRAW, $urandom);
		drain_draws();

		// Random bursts; mostly draws so the pointers wrap many times per seed
		while (items_sent < NUM_ITEMS) begin
			burst_len = $urandom_range(1, 24);
			repeat (burst_len) begin
				if ($urandom_range(0, 24) == 0) begin
					issue(CMD_RESEED, pick_seed());
				end else begin
					issue(CMD_DRAW, $urandom);
				end
			end
			if ($urandom_range(0, 15) == 0) begin
				drain_draws();
			end else if ($urandom_range(0, 3) != 0) begin
				idle_for($urandom_range(1, 12));
			end
		end

		// Wind down: wait for the last results, then let the pipeline settle
		drain_draws();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (err_count == 0 && draws_pending == 0) begin
			$display("tb_additive_lagged_fibonacci_rng_core OK");
		end else begin
			$display("tb_additive_lagged_fibonacci_rng_core NOT OK");
		end
		$finish;
	end

endmodule
